/* sv/lpg_pkg.sv */
`timescale 1ns / 1ps

package lpg_pkg;

	localparam int NUM_LEDS_DEF = 2;

	localparam int HALF_W   = 16;
	localparam int LEN_W    = 7;
	localparam int TCNT_W   = 8;
	localparam int DIV_W    = HALF_W + 1;
	localparam int DIVR_W   = 8;
	localparam int DIV_CNT_W = $clog2(DIV_W + 1);

	// (2^17 + 1) / 3: x * THIRD_RECIP >> DIV_W is exactly x / 3 for x below 2^17
	localparam logic [DIV_W-1:0] THIRD_RECIP = DIV_W'(43691);

	localparam logic OP_TICK = 1'b0;
	localparam logic OP_CMD  = 1'b1;

	localparam logic [2:0] MODE_OFF    = 3'd0;
	localparam logic [2:0] MODE_ON     = 3'd1;
	localparam logic [2:0] MODE_TOGGLE = 3'd2;
	localparam logic [2:0] MODE_BLINK  = 3'd3;
	localparam logic [2:0] MODE_HEART  = 3'd4;
	localparam logic [2:0] MODE_PULSE  = 3'd5;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_DIV_A,
		S_DIV_B,
		S_WRITE,
		S_TICK,
		S_DONE
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic capture;
		logic div_start;
		logic div_sel_b;
		logic save_a;
		logic save_b;
		logic cmd_write;
		logic tick_write;
	} ctl_t;

	// datapath -> controller
	typedef struct packed {
		logic is_cmd;
		logic cmd_ok;
		logic div_done;
	} sts_t;

endpackage

/* sv/lpg_divider.sv */
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle.
module lpg_divider (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [lpg_pkg::DIV_W-1:0]   dividend,
	input  logic [lpg_pkg::DIVR_W-1:0]  divisor,
	output logic                        done,
	output logic [lpg_pkg::DIV_W-1:0]   quotient
);

	logic                           run_q;
	logic                           done_q;
	logic [lpg_pkg::DIV_CNT_W-1:0]  cnt_q;
	logic [lpg_pkg::DIVR_W-1:0]     rem_q;
	logic [lpg_pkg::DIVR_W-1:0]     divr_q;
	logic [lpg_pkg::DIV_W-1:0]      quo_q;
	logic [lpg_pkg::DIVR_W:0]       trial;
	logic                           ge;

	assign trial = {rem_q, quo_q[lpg_pkg::DIV_W-1]};
	assign ge    = trial >= {1'b0, divr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= lpg_pkg::DIV_CNT_W'(lpg_pkg::DIV_W);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == lpg_pkg::DIV_CNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			divr_q <= divisor;
			quo_q  <= dividend;
		end else if (run_q) begin
			rem_q <= ge ? lpg_pkg::DIVR_W'(trial - {1'b0, divr_q}) : trial[lpg_pkg::DIVR_W-1:0];
			quo_q <= {quo_q[lpg_pkg::DIV_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

/* sv/lpg_datapath.sv */
`timescale 1ns / 1ps

module lpg_datapath #(
	parameter int NUM_LEDS = lpg_pkg::NUM_LEDS_DEF,
	parameter int IDX_W    = 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        op,
	input  logic                        led_index,
	input  logic [2:0]                  mode,
	input  logic [lpg_pkg::HALF_W-1:0]  half_period,
	input  logic [lpg_pkg::LEN_W-1:0]   train_length,
	input  lpg_pkg::ctl_t               ctl,
	input  logic [IDX_W-1:0]            walk_idx,
	output lpg_pkg::sts_t               sts,
	output logic [1:0]                  led_on
);

	// captured transaction
	logic                        in_op_q;
	logic                        in_idx_q;
	logic [2:0]                  in_mode_q;
	logic [lpg_pkg::HALF_W-1:0]  in_half_q;
	logic [lpg_pkg::LEN_W-1:0]   in_len_q;
	logic [lpg_pkg::HALF_W-1:0]  res_a_q;
	logic [lpg_pkg::HALF_W-1:0]  res_b_q;

	// per-LED state
	logic [2:0]                  led_mode_q [NUM_LEDS];
	logic [lpg_pkg::HALF_W-1:0]  st_half_q  [NUM_LEDS];
	logic [lpg_pkg::LEN_W-1:0]   st_len_q   [NUM_LEDS];
	logic [lpg_pkg::HALF_W-1:0]  cnt_q      [NUM_LEDS];
	logic                        phase_q    [NUM_LEDS];
	logic [lpg_pkg::TCNT_W-1:0]  tcnt_q     [NUM_LEDS];
	logic [lpg_pkg::HALF_W-1:0]  qa_q       [NUM_LEDS];
	logic [lpg_pkg::HALF_W-1:0]  qb_q       [NUM_LEDS];
	logic [NUM_LEDS-1:0]         level_q;

	logic [IDX_W-1:0]            sel;
	logic                        in_heart;
	logic                        in_pulse;
	logic [lpg_pkg::TCNT_W-1:0]  in_toggles;
	logic [lpg_pkg::DIV_W-1:0]   div_dividend;
	logic [lpg_pkg::DIVR_W-1:0]  div_divisor;
	logic                        div_done;
	logic [lpg_pkg::DIV_W-1:0]   div_quo;
	logic [lpg_pkg::HALF_W-1:0]  quo_fix;
	logic [lpg_pkg::DIV_W-1:0]   third_in;
	logic [2*lpg_pkg::DIV_W-1:0] third_prod;
	logic [lpg_pkg::HALF_W-1:0]  third;

	// tick update of the selected LED
	logic [2:0]                  cur_mode;
	logic [lpg_pkg::HALF_W-1:0]  cur_half;
	logic [lpg_pkg::TCNT_W-1:0]  cur_toggles;
	logic [lpg_pkg::HALF_W-1:0]  dec;
	logic                        dec_zero;
	logic [lpg_pkg::HALF_W-1:0]  nxt_cnt;
	logic                        nxt_phase;
	logic [lpg_pkg::TCNT_W-1:0]  nxt_tcnt;
	logic                        nxt_level;

	assign sel = (in_op_q == lpg_pkg::OP_CMD) ? IDX_W'(in_idx_q) : walk_idx;

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			in_op_q   <= op;
			in_idx_q  <= led_index;
			in_mode_q <= mode;
			in_half_q <= (half_period == '0) ? lpg_pkg::HALF_W'(1) : half_period;
			in_len_q  <= (train_length == '0) ? lpg_pkg::LEN_W'(1) : train_length;
		end
		if (ctl.save_a) res_a_q <= quo_fix;
		if (ctl.save_b) res_b_q <= quo_fix;
	end

	// heartbeat: 2h/3 then h/3 by reciprocal multiply;
	// pulse train: h/(2L-1) then h/L on the divider, at least 1
	assign in_heart   = in_mode_q == lpg_pkg::MODE_HEART;
	assign in_pulse   = in_mode_q == lpg_pkg::MODE_PULSE;
	assign in_toggles = {in_len_q, 1'b0} - 1'b1;

	assign third_in   = ctl.save_a ? {in_half_q, 1'b0} : {1'b0, in_half_q};
	assign third_prod = third_in * lpg_pkg::THIRD_RECIP;
	assign third      = third_prod[lpg_pkg::DIV_W +: lpg_pkg::HALF_W];

	assign div_dividend = {1'b0, in_half_q};

	always_comb begin
		if (ctl.div_sel_b) begin
			div_divisor = {1'b0, in_len_q};
		end else begin
			div_divisor = in_toggles;
		end
	end

	lpg_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (ctl.div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_comb begin
		priority if (in_heart) begin
			quo_fix = third;
		end else if (in_pulse && div_quo[lpg_pkg::HALF_W-1:0] == '0) begin
			quo_fix = lpg_pkg::HALF_W'(1);
		end else begin
			quo_fix = div_quo[lpg_pkg::HALF_W-1:0];
		end
	end

	assign cur_mode    = led_mode_q[sel];
	assign cur_half    = st_half_q[sel];
	assign cur_toggles = {st_len_q[sel], 1'b0} - 1'b1;
	assign dec         = cnt_q[sel] - 1'b1;
	assign dec_zero    = dec == '0;

	always_comb begin
		nxt_cnt   = cnt_q[sel];
		nxt_phase = phase_q[sel];
		nxt_tcnt  = tcnt_q[sel];
		nxt_level = level_q[sel];
		unique case (cur_mode)
			lpg_pkg::MODE_BLINK: begin
				nxt_cnt = dec;
				if (dec_zero) begin
					nxt_level = ~level_q[sel];
					nxt_cnt   = cur_half;
				end
			end
			lpg_pkg::MODE_HEART: begin
				nxt_cnt = dec;
				if (!phase_q[sel]) begin
					// zero point wins over the 2/3 and 1/3 points
					priority if (dec_zero) begin
						nxt_level = ~level_q[sel];
						nxt_phase = 1'b1;
						nxt_cnt   = cur_half;
					end else if (dec == qa_q[sel] || dec == qb_q[sel]) begin
						nxt_level = ~level_q[sel];
					end
				end else if (dec_zero) begin
					nxt_level = ~level_q[sel];
					nxt_phase = 1'b0;
					nxt_cnt   = cur_half;
				end
			end
			lpg_pkg::MODE_PULSE: begin
				nxt_cnt = dec;
				if (!phase_q[sel]) begin
					if (dec_zero) begin
						if (tcnt_q[sel] < cur_toggles) begin
							nxt_level = ~level_q[sel];
							nxt_cnt   = qa_q[sel];
							nxt_tcnt  = tcnt_q[sel] + 1'b1;
						end else begin
							nxt_level = 1'b0;
							nxt_cnt   = cur_half;
							nxt_tcnt  = '0;
							nxt_phase = 1'b1;
						end
					end
				end else if (dec_zero) begin
					nxt_level = ~level_q[sel];
					nxt_cnt   = qb_q[sel];
					nxt_phase = 1'b0;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_LEDS; i++) begin
				led_mode_q[i] <= lpg_pkg::MODE_OFF;
			end
			level_q <= '0;
		end else if (ctl.cmd_write) begin
			led_mode_q[sel] <= in_mode_q;
			unique case (in_mode_q)
				lpg_pkg::MODE_OFF:    level_q[sel] <= 1'b0;
				lpg_pkg::MODE_ON:     level_q[sel] <= 1'b1;
				lpg_pkg::MODE_TOGGLE: level_q[sel] <= ~level_q[sel];
				default: begin
				end
			endcase
		end else if (ctl.tick_write) begin
			level_q[sel] <= nxt_level;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.cmd_write) begin
			st_half_q[sel] <= in_half_q;
			st_len_q[sel]  <= in_len_q;
			qa_q[sel]      <= res_a_q;
			qb_q[sel]      <= res_b_q;
			unique case (in_mode_q)
				lpg_pkg::MODE_BLINK: cnt_q[sel] <= in_half_q;
				lpg_pkg::MODE_HEART: begin
					cnt_q[sel]   <= in_half_q;
					phase_q[sel] <= 1'b1;
				end
				lpg_pkg::MODE_PULSE: begin
					cnt_q[sel]   <= in_half_q;
					phase_q[sel] <= 1'b0;
					tcnt_q[sel]  <= '0;
				end
				default: begin
				end
			endcase
		end else if (ctl.tick_write) begin
			cnt_q[sel]   <= nxt_cnt;
			phase_q[sel] <= nxt_phase;
			tcnt_q[sel]  <= nxt_tcnt;
		end
	end

	assign sts.is_cmd   = in_op_q == lpg_pkg::OP_CMD;
	assign sts.cmd_ok   = (in_idx_q == 1'b0) || (NUM_LEDS > 1);
	assign sts.div_done = div_done;

	for (genvar b = 0; b < 2; b++) begin : g_out
		if (b < NUM_LEDS) begin : g_led
			assign led_on[b] = level_q[b];
		end else begin : g_none
			assign led_on[b] = 1'b0;
		end
	end

endmodule

/* sv/lpg_controller.sv */
`timescale 1ns / 1ps

module lpg_controller #(
	parameter int NUM_LEDS = lpg_pkg::NUM_LEDS_DEF,
	parameter int IDX_W    = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  lpg_pkg::sts_t     sts,
	output lpg_pkg::ctl_t     ctl,
	output logic [IDX_W-1:0]  walk_idx,
	output logic              busy,
	output logic              done
);

	lpg_pkg::state_t  state_q;
	lpg_pkg::state_t  state_nxt;
	logic [IDX_W-1:0] walk_q;
	logic             walk_last;

	assign walk_last = walk_q == IDX_W'(NUM_LEDS - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lpg_pkg::S_IDLE;
			walk_q  <= '0;
		end else begin
			state_q <= state_nxt;
			if (state_q == lpg_pkg::S_DECODE) begin
				walk_q <= '0;
			end else if (state_q == lpg_pkg::S_TICK) begin
				walk_q <= walk_q + 1'b1;
			end
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			lpg_pkg::S_IDLE:   if (start) state_nxt = lpg_pkg::S_DECODE;
			lpg_pkg::S_DECODE: begin
				priority if (!sts.is_cmd) state_nxt = lpg_pkg::S_TICK;
				else if (!sts.cmd_ok)     state_nxt = lpg_pkg::S_DONE;
				else                      state_nxt = lpg_pkg::S_DIV_A;
			end
			lpg_pkg::S_DIV_A:  if (sts.div_done) state_nxt = lpg_pkg::S_DIV_B;
			lpg_pkg::S_DIV_B:  if (sts.div_done) state_nxt = lpg_pkg::S_WRITE;
			lpg_pkg::S_WRITE:  state_nxt = lpg_pkg::S_DONE;
			lpg_pkg::S_TICK:   if (walk_last) state_nxt = lpg_pkg::S_DONE;
			lpg_pkg::S_DONE:   state_nxt = lpg_pkg::S_IDLE;
			default:           state_nxt = lpg_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		ctl  = '0;
		busy = 1'b1;
		done = 1'b0;
		unique case (state_q)
			lpg_pkg::S_IDLE: begin
				busy        = 1'b0;
				ctl.capture = start;
			end
			lpg_pkg::S_DECODE: ctl.div_start = 1'b1;
			lpg_pkg::S_DIV_A: begin
				ctl.save_a    = sts.div_done;
				ctl.div_start = sts.div_done;
				ctl.div_sel_b = sts.div_done;
			end
			lpg_pkg::S_DIV_B: begin
				ctl.div_sel_b = 1'b1;
				ctl.save_b    = sts.div_done;
			end
			lpg_pkg::S_WRITE: ctl.cmd_write  = 1'b1;
			lpg_pkg::S_TICK:  ctl.tick_write = 1'b1;
			lpg_pkg::S_DONE:  done = 1'b1;
			default: begin
			end
		endcase
	end

	assign walk_idx = walk_q;

endmodule

/* sv/led_pattern_generator_unit.sv */
`timescale 1ns / 1ps

// LED pattern generator: NUM_LEDS independent LEDs, each running off, on,
// toggle, blink, heartbeat or pulse-train patterns.
//
// Input channel: a transaction is taken on a rising edge with start high and
// busy low. op selects a 1 ms tick (advances every LED) or a mode command for
// the LED at led_index (mode, half_period, train_length; zero half period or
// length is stored as 1; an index past the last LED is ignored).
// Result channel: done is high for exactly one cycle with the LED-on vector
// on led_on. The receiver cannot stall; it must take done when it shows.
// One result per transaction, in order.
//
// Sequence after acceptance:
//   command:        decode, then two 17-step divisions (one quotient bit
//                   per cycle), then the write, then done.
//   ignored index:  decode, then done.
//   tick:           decode, then the LED state is walked one LED per
//                   cycle, then done.
// busy stays high from acceptance through the done cycle.
//
// Reset (arst_n low, async): all LEDs off in mode off, controller idle.
module led_pattern_generator_unit #(
	parameter int NUM_LEDS = lpg_pkg::NUM_LEDS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic                        op,
	input  logic                        led_index,
	input  logic [2:0]                  mode,
	input  logic [lpg_pkg::HALF_W-1:0]  half_period,
	input  logic [lpg_pkg::LEN_W-1:0]   train_length,
	output logic                        done,
	output logic [1:0]                  led_on
);

	localparam int IDX_W = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;

	lpg_pkg::ctl_t     ctl;
	lpg_pkg::sts_t     sts;
	logic [IDX_W-1:0]  walk_idx;

	// sequencer: decode, divisions for commands, LED walk for ticks
	lpg_controller #(
		.NUM_LEDS (NUM_LEDS),
		.IDX_W    (IDX_W)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.sts      (sts),
		.ctl      (ctl),
		.walk_idx (walk_idx),
		.busy     (busy),
		.done     (done)
	);

	// per-LED state, pattern update logic and the shared divider
	lpg_datapath #(
		.NUM_LEDS (NUM_LEDS),
		.IDX_W    (IDX_W)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.op           (op),
		.led_index    (led_index),
		.mode         (mode),
		.half_period  (half_period),
		.train_length (train_length),
		.ctl          (ctl),
		.walk_idx     (walk_idx),
		.sts          (sts),
		.led_on       (led_on)
	);

endmodule

/* sv/lpg_checker.sv */
`timescale 1ns / 1ps

module lpg_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done
);

	// an accepted transaction keeps the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after accepted transaction");

	// result strobe lasts one cycle
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held longer than one cycle");

	// a result only shows while a transaction is in flight
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("done without busy");

	// busy drops only right after the result was delivered
	a_busy_fall: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> $past(done))
		else $error("busy dropped without a result");

endmodule

bind led_pattern_generator_unit lpg_checker u_lpg_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done)
);
